// ===== hdl/mpsb_pkg.sv =====
// Shared types and constants for the multichannel ping-pong stream buffer.
// Used by multichannel_pingpong_stream_buffer; no dependencies.
package mpsb_pkg;

  // Default sizing
  localparam int DEF_CHANNELS      = 16;
  localparam int DEF_CHANNEL_BYTES = 4096;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int CH_W    = 4;
  localparam int LEN_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int FLAGS_W = 5;

  // Channel flag bit positions
  localparam int FLAG_IN_USE    = 0;
  localparam int FLAG_FIRST_RUN = 1;
  localparam int FLAG_ALLOC     = 2;
  localparam int FLAG_H0_FULL   = 3;
  localparam int FLAG_H1_FULL   = 4;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_WSTART = 3'd2,
    OP_WBYTE  = 3'd3,
    OP_RSWAP  = 3'd4,
    OP_FETCH  = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CH_W-1:0]   channel;
    logic              pick_free;
    logic [LEN_W-1:0]  write_length;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [CH_W-1:0]    channel_out;
    logic [ADDR_W-1:0]  buffer_offset;
    logic [LEN_W-1:0]   buffer_length;
    logic [FLAGS_W-1:0] status_bits;
    logic               overflow;
    logic               dropped;
    logic [BYTE_W-1:0]  fetch_data;
  } out_item_t;

endpackage

// ===== hdl/mpsb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/multichannel_pingpong_stream_buffer.sv =====
// Multichannel ping-pong stream buffer: top level.
// Requests pass the stage-1 register, then the output register when the output is free.
// Throughput: one request per cycle while the output is not stalled; the fill memory and
// stream memory are read at accept and written back when stage 1 fires, with last-write forwarding.
// Reset: channel flags, fill valid bits and writer state clear at once;
// stream memory content is undefined until written; no clearing pass.
module multichannel_pingpong_stream_buffer #(
  parameter int CHANNELS      = mpsb_pkg::DEF_CHANNELS,
  parameter int CHANNEL_BYTES = mpsb_pkg::DEF_CHANNEL_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpsb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpsb_pkg::out_item_t out_data
);

  localparam int HALF_BYTES = CHANNEL_BYTES / 2;
  localparam int MEM_BYTES  = CHANNELS * CHANNEL_BYTES;
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int FILL_W     = $clog2(HALF_BYTES + 1);
  localparam int SUM_W      = ((FILL_W > mpsb_pkg::LEN_W) ? FILL_W : mpsb_pkg::LEN_W) + 1;
  localparam int FLAGS_W    = mpsb_pkg::FLAGS_W;
  localparam int BYTE_W     = mpsb_pkg::BYTE_W;

  // Control state
  logic               s1_v_r;
  logic               out_valid_r;
  logic [FLAGS_W-1:0] flags_r [CHANNELS];
  logic [CHANNELS-1:0] fill_vld_r;
  logic [CH_AW-1:0]   writer_channel_r;
  logic               writer_half_r;
  logic               writer_open_r;
  logic               lf_v_r;
  logic               lw_v_r;

  // Payload state
  mpsb_pkg::in_item_t  s1_item_r;
  logic [CH_AW-1:0]    s1_fidx_r;
  logic                s1_ch_ok_r;
  logic                s1_addr_ok_r;
  mpsb_pkg::out_item_t out_data_r;
  logic [CH_AW-1:0]    lf_addr_r;
  logic [2*FILL_W-1:0] lf_data_r;
  logic [MEM_AW-1:0]   lw_addr_r;
  logic [BYTE_W-1:0]   lw_data_r;

  // Handshake
  logic in_acc;
  logic out_free;
  logic s1_fire;

  // Memory ports
  logic [CH_AW-1:0]    fidx_nxt;
  logic [2*FILL_W-1:0] fill_dout;
  logic                fw_we;
  logic [2*FILL_W-1:0] fw_data;
  logic [BYTE_W-1:0]   sm_dout;
  logic                sm_we;
  logic [MEM_AW-1:0]   sm_addr;

  // Stage-1 results
  logic                flag_we;
  logic [CH_AW-1:0]    flag_idx;
  logic [FLAGS_W-1:0]  flag_val;
  logic                writer_we;
  logic                writer_half_nxt;
  logic                writer_open_nxt;
  mpsb_pkg::out_item_t res;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || out_free;
  assign in_acc   = in_valid && in_ready;
  assign s1_fire  = s1_v_r && out_free;

  // Fill index: write byte follows the writer channel, forwarding a write start
  // that commits in this same cycle
  always_comb begin
    if (in_data.opcode == mpsb_pkg::OP_WBYTE) begin
      if (s1_v_r && s1_item_r.opcode == mpsb_pkg::OP_WSTART) begin
        fidx_nxt = CH_AW'(s1_item_r.channel);
      end else begin
        fidx_nxt = writer_channel_r;
      end
    end else begin
      fidx_nxt = CH_AW'(in_data.channel);
    end
  end

  // Per-channel fill counters, both halves in one word
  mpsb_ram #(
    .WIDTH (2 * FILL_W),
    .DEPTH (CHANNELS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (s1_fire && fw_we),
    .waddr (s1_fidx_r),
    .wdata (fw_data),
    .re    (in_acc),
    .raddr (fidx_nxt),
    .rdata (fill_dout)
  );

  // Shared stream memory
  mpsb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_stream_ram (
    .clk   (clk),
    .we    (s1_fire && sm_we),
    .waddr (sm_addr),
    .wdata (s1_item_r.data_byte),
    .re    (in_acc),
    .raddr (MEM_AW'(in_data.byte_address)),
    .rdata (sm_dout)
  );

  // Stage-1 request decode and read-modify-write
  always_comb begin
    logic [2*FILL_W-1:0] fill_rd;
    logic [FILL_W-1:0]   fill0;
    logic [FILL_W-1:0]   fill1;
    logic [FILL_W-1:0]   fill_sel;
    logic [FLAGS_W-1:0]  cur;
    logic [FLAGS_W-1:0]  upd;
    logic                half;
    logic                found;
    logic [CH_AW-1:0]    pick_idx;
    logic [31:0]         off_full;
    logic [31:0]         wr_full;

    // Forward the last fill write; an entry never written reads zero
    if (lf_v_r && lf_addr_r == s1_fidx_r) begin
      fill_rd = lf_data_r;
    end else if (fill_vld_r[s1_fidx_r]) begin
      fill_rd = fill_dout;
    end else begin
      fill_rd = '0;
    end
    fill0    = fill_rd[FILL_W-1:0];
    fill1    = fill_rd[2*FILL_W-1:FILL_W];
    cur      = flags_r[s1_fidx_r];
    half     = cur[mpsb_pkg::FLAG_IN_USE];
    fill_sel = half ? fill1 : fill0;
    upd      = cur;

    // First channel whose flags are all zero
    found    = 1'b0;
    pick_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (flags_r[i] == '0) begin
        found    = 1'b1;
        pick_idx = CH_AW'(i);
      end
    end

    off_full = 32'(s1_item_r.channel) * 32'(CHANNEL_BYTES)
             + (half ? 32'(HALF_BYTES) : 32'd0);
    wr_full  = 32'(writer_channel_r) * 32'(CHANNEL_BYTES)
             + (writer_half_r ? 32'(HALF_BYTES) : 32'd0)
             + 32'(writer_half_r ? fill1 : fill0);

    flag_we         = 1'b0;
    flag_idx        = s1_fidx_r;
    flag_val        = cur;
    fw_we           = 1'b0;
    fw_data         = fill_rd;
    sm_we           = 1'b0;
    sm_addr         = wr_full[MEM_AW-1:0];
    writer_we       = 1'b0;
    writer_half_nxt = writer_half_r;
    writer_open_nxt = writer_open_r;
    res             = '0;

    case (s1_item_r.opcode)
      mpsb_pkg::OP_ALLOC: begin
        if (s1_item_r.pick_free) begin
          if (found) begin
            flag_we                                = 1'b1;
            flag_idx                               = pick_idx;
            flag_val                               = '0;
            flag_val[mpsb_pkg::FLAG_ALLOC]         = 1'b1;
            flag_val[mpsb_pkg::FLAG_FIRST_RUN]     = 1'b1;
            res.ok                                 = 1'b1;
            res.channel_out                        = mpsb_pkg::CH_W'(pick_idx);
            res.status_bits                        = flag_val;
          end
        end else if (s1_ch_ok_r) begin
          upd[mpsb_pkg::FLAG_ALLOC]     = 1'b1;
          upd[mpsb_pkg::FLAG_FIRST_RUN] = 1'b1;
          flag_we                       = 1'b1;
          flag_val                      = upd;
          res.ok                        = 1'b1;
          res.channel_out               = s1_item_r.channel;
          res.status_bits               = upd;
        end
      end
      mpsb_pkg::OP_FREE: begin
        if (s1_ch_ok_r) begin
          flag_we  = 1'b1;
          flag_val = '0;
          fw_we    = 1'b1;
          fw_data  = '0;
          res.ok   = 1'b1;
        end
      end
      mpsb_pkg::OP_WSTART: begin
        writer_we = 1'b1;
        if (s1_ch_ok_r && cur[mpsb_pkg::FLAG_ALLOC]) begin
          writer_half_nxt = half;
          if (SUM_W'(fill_sel) + SUM_W'(s1_item_r.write_length) > SUM_W'(HALF_BYTES)) begin
            if (half) begin
              upd[mpsb_pkg::FLAG_H1_FULL] = 1'b1;
            end else begin
              upd[mpsb_pkg::FLAG_H0_FULL] = 1'b1;
            end
            writer_half_nxt = !half;
            res.overflow    = 1'b1;
          end
          flag_we         = 1'b1;
          flag_val        = upd;
          writer_open_nxt = 1'b1;
          res.ok          = 1'b1;
          res.status_bits = upd;
        end else begin
          writer_open_nxt = 1'b0;
        end
      end
      mpsb_pkg::OP_WBYTE: begin
        if (writer_open_r && cur[mpsb_pkg::FLAG_ALLOC]) begin
          if ((writer_half_r ? fill1 : fill0) >= FILL_W'(HALF_BYTES)) begin
            res.dropped = 1'b1;
          end else begin
            sm_we = 1'b1;
            fw_we = 1'b1;
            if (writer_half_r) begin
              fw_data[2*FILL_W-1:FILL_W] = fill1 + 1'b1;
            end else begin
              fw_data[FILL_W-1:0] = fill0 + 1'b1;
            end
          end
          res.ok          = 1'b1;
          res.status_bits = cur;
        end
      end
      mpsb_pkg::OP_RSWAP: begin
        if (s1_ch_ok_r) begin
          upd[mpsb_pkg::FLAG_IN_USE] = !half;
          flag_we                    = 1'b1;
          flag_val                   = upd;
          fw_we                      = 1'b1;
          if (half) begin
            fw_data[2*FILL_W-1:FILL_W] = '0;
          end else begin
            fw_data[FILL_W-1:0] = '0;
          end
          res.ok            = 1'b1;
          res.buffer_offset = off_full[mpsb_pkg::ADDR_W-1:0];
          res.buffer_length = mpsb_pkg::LEN_W'(fill_sel);
          res.status_bits   = upd;
        end
      end
      mpsb_pkg::OP_FETCH: begin
        if (s1_addr_ok_r) begin
          res.ok = 1'b1;
          if (lw_v_r && lw_addr_r == MEM_AW'(s1_item_r.byte_address)) begin
            res.fetch_data = lw_data_r;
          end else begin
            res.fetch_data = sm_dout;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Stage-1 valid and output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r    <= in_data;
      s1_fidx_r    <= fidx_nxt;
      s1_ch_ok_r   <= 32'(in_data.channel) < 32'(CHANNELS);
      s1_addr_ok_r <= 32'(in_data.byte_address) < 32'(MEM_BYTES);
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  // Commit channel flags, fill valid bits and writer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        flags_r[i] <= '0;
      end
      fill_vld_r       <= '0;
      writer_channel_r <= '0;
      writer_half_r    <= 1'b0;
      writer_open_r    <= 1'b0;
      lf_v_r           <= 1'b0;
      lw_v_r           <= 1'b0;
    end else if (s1_fire) begin
      if (flag_we) begin
        flags_r[flag_idx] <= flag_val;
      end
      if (fw_we) begin
        fill_vld_r[s1_fidx_r] <= 1'b1;
        lf_v_r                <= 1'b1;
      end
      if (sm_we) begin
        lw_v_r <= 1'b1;
      end
      if (writer_we) begin
        writer_channel_r <= s1_fidx_r;
        writer_half_r    <= writer_half_nxt;
        writer_open_r    <= writer_open_nxt;
      end
    end
  end

  // Hold the last fill and stream writes for forwarding
  always_ff @(posedge clk) begin
    if (s1_fire && fw_we) begin
      lf_addr_r <= s1_fidx_r;
      lf_data_r <= fw_data;
    end
    if (s1_fire && sm_we) begin
      lw_addr_r <= sm_addr;
      lw_data_r <= s1_item_r.data_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_pingpong_stream_buffer: queued requests
// with random gaps and stalls, replies checked in order against a behavioral model.
// Depends on mpsb_pkg and the multichannel_pingpong_stream_buffer RTL.
module testbench;

  localparam int NCH        = mpsb_pkg::DEF_CHANNELS;
  localparam int CH_BYTES   = mpsb_pkg::DEF_CHANNEL_BYTES;
  localparam int HALF       = CH_BYTES / 2;
  localparam int MEM_SIZE   = NCH * CH_BYTES;
  localparam int TOTAL_REQS = 2400;
  localparam int MAX_SHOWN  = 10;
  localparam int OP_BITS    = mpsb_pkg::OP_W;
  localparam int CH_BITS    = mpsb_pkg::CH_W;
  localparam int LEN_BITS   = mpsb_pkg::LEN_W;
  localparam int ADDR_BITS  = mpsb_pkg::ADDR_W;
  localparam int FLAG_BITS  = mpsb_pkg::FLAGS_W;
  localparam logic [OP_BITS-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE7 = 3'd7;
  localparam logic [FLAG_BITS-1:0] NEW_CHANNEL =
    FLAG_BITS'((1 << mpsb_pkg::FLAG_ALLOC) | (1 << mpsb_pkg::FLAG_FIRST_RUN));

  typedef struct packed {
    mpsb_pkg::in_item_t  req;
    mpsb_pkg::out_item_t rsp;
  } pending_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mpsb_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mpsb_pkg::out_item_t out_data;

  multichannel_pingpong_stream_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Buffer model state
  logic [FLAG_BITS-1:0] flag_m [NCH];
  logic [LEN_BITS-1:0]  fill_m [NCH][2];
  logic [7:0]           mem_m [MEM_SIZE];
  bit                   mem_written [MEM_SIZE];
  int                   written_q[$];
  int                   writer_ch_m;
  int                   writer_half_m;
  bit                   writer_open_m;

  pending_t            request_q[$];
  mpsb_pkg::out_item_t replies_due[$];
  mpsb_pkg::out_item_t held_reply;
  mpsb_pkg::out_item_t want_reply;
  int unsigned         cycle_n = 0;
  int                  errors  = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
  end

  // Idle about a third of the time, except in one steady window
  function automatic bit take_break();
    if (cycle_n >= 1000 && cycle_n < 2500) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  // Apply one request to the model and return the reply it must produce
  function automatic mpsb_pkg::out_item_t predict_reply(mpsb_pkg::in_item_t r);
    mpsb_pkg::out_item_t o;
    int                  c;
    int                  h;
    int                  a;
    bit                  found;
    o     = '0;
    c     = int'(r.channel);
    found = 1'b0;
    case (r.opcode)
      mpsb_pkg::OP_ALLOC: begin
        if (r.pick_free) begin
          for (int k = 0; k < NCH; k++) begin
            if (!found && flag_m[k] == '0) begin
              flag_m[k]     = NEW_CHANNEL;
              o.ok          = 1'b1;
              o.channel_out = k[CH_BITS-1:0];
              o.status_bits = flag_m[k];
              found         = 1'b1;
            end
          end
        end else begin
          flag_m[c]     = flag_m[c] | NEW_CHANNEL;
          o.ok          = 1'b1;
          o.channel_out = r.channel;
          o.status_bits = flag_m[c];
        end
      end
      mpsb_pkg::OP_FREE: begin
        flag_m[c]    = '0;
        fill_m[c][0] = '0;
        fill_m[c][1] = '0;
        o.ok         = 1'b1;
      end
      mpsb_pkg::OP_WSTART: begin
        if (flag_m[c][mpsb_pkg::FLAG_ALLOC]) begin
          h = int'(flag_m[c][mpsb_pkg::FLAG_IN_USE]);
          // Divert to the other half when the announced length does not fit
          if (int'(fill_m[c][h]) + int'(r.write_length) > HALF) begin
            flag_m[c][h ? mpsb_pkg::FLAG_H1_FULL : mpsb_pkg::FLAG_H0_FULL] = 1'b1;
            h          = h ^ 1;
            o.overflow = 1'b1;
          end
          writer_ch_m   = c;
          writer_half_m = h;
          writer_open_m = 1'b1;
          o.ok          = 1'b1;
          o.status_bits = flag_m[c];
        end else begin
          writer_open_m = 1'b0;
        end
      end
      mpsb_pkg::OP_WBYTE: begin
        if (writer_open_m && flag_m[writer_ch_m][mpsb_pkg::FLAG_ALLOC]) begin
          if (fill_m[writer_ch_m][writer_half_m] >= HALF) begin
            o.dropped = 1'b1;
          end else begin
            a = writer_ch_m * CH_BYTES + writer_half_m * HALF +
                int'(fill_m[writer_ch_m][writer_half_m]);
            mem_m[a] = r.data_byte;
            if (!mem_written[a]) begin
              mem_written[a] = 1'b1;
              written_q.push_back(a);
            end
            fill_m[writer_ch_m][writer_half_m] = fill_m[writer_ch_m][writer_half_m] + 1'b1;
          end
          o.ok          = 1'b1;
          o.status_bits = flag_m[writer_ch_m];
        end
      end
      mpsb_pkg::OP_RSWAP: begin
        h = int'(flag_m[c][mpsb_pkg::FLAG_IN_USE]);
        flag_m[c][mpsb_pkg::FLAG_IN_USE] = ~flag_m[c][mpsb_pkg::FLAG_IN_USE];
        o.buffer_offset = ADDR_BITS'(c * CH_BYTES + h * HALF);
        o.buffer_length = fill_m[c][h];
        fill_m[c][h]    = '0;
        o.ok            = 1'b1;
        o.status_bits   = flag_m[c];
      end
      mpsb_pkg::OP_FETCH: begin
        o.fetch_data = mem_m[r.byte_address];
        o.ok         = 1'b1;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Request with the given opcode and channel, all other fields random
  function automatic mpsb_pkg::in_item_t rand_req(logic [OP_BITS-1:0] op, int ch);
    mpsb_pkg::in_item_t r;
    r.opcode       = op;
    r.channel      = ch[CH_BITS-1:0];
    r.pick_free    = 1'($urandom_range(0, 1));
    r.write_length = LEN_BITS'($urandom_range(0, 4095));
    r.data_byte    = 8'($urandom_range(0, 255));
    r.byte_address = ADDR_BITS'($urandom_range(0, 65535));
    return r;
  endfunction

  // Fetch of a byte that has already been written
  function automatic mpsb_pkg::in_item_t fetch_req();
    mpsb_pkg::in_item_t r;
    r = rand_req(mpsb_pkg::OP_FETCH, $urandom_range(0, NCH - 1));
    r.byte_address = ADDR_BITS'(written_q[$urandom_range(0, written_q.size() - 1)]);
    return r;
  endfunction

  // Any opcode, including the unused ones
  function automatic mpsb_pkg::in_item_t noise_req();
    logic [OP_BITS-1:0] op;
    op = OP_BITS'($urandom_range(0, 7));
    if (op == mpsb_pkg::OP_FETCH) return fetch_req();
    return rand_req(op, $urandom_range(0, NCH - 1));
  endfunction

  // Allocated channel near a random start, or -1 when none is allocated
  function automatic int pick_allocated();
    int s;
    s = $urandom_range(0, NCH - 1);
    for (int k = 0; k < NCH; k++) begin
      if (flag_m[(s + k) % NCH][mpsb_pkg::FLAG_ALLOC]) return (s + k) % NCH;
    end
    return -1;
  endfunction

  task automatic queue_req(mpsb_pkg::in_item_t r);
    pending_t p;
    p.req = r;
    p.rsp = predict_reply(r);
    request_q.push_back(p);
  endtask

  // Request driver: load the next request when the channel is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        replies_due.push_back(held_reply);
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && !take_break()) begin
          in_data    <= request_q[0].req;
          held_reply  = request_q[0].rsp;
          request_q.delete(0);
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: compare each reply with the oldest one due
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: reply with none due: %h", $time, out_data);
        end else begin
          want_reply = replies_due.pop_front();
          if (out_data.ok !== want_reply.ok ||
              out_data.channel_out !== want_reply.channel_out ||
              out_data.buffer_offset !== want_reply.buffer_offset ||
              out_data.buffer_length !== want_reply.buffer_length ||
              out_data.status_bits !== want_reply.status_bits ||
              out_data.overflow !== want_reply.overflow ||
              out_data.dropped !== want_reply.dropped ||
              out_data.fetch_data !== want_reply.fetch_data) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $display("%0t: mismatch exp ok=%0d ch=%0d off=%h len=%0d st=%b",
                       $time, want_reply.ok, want_reply.channel_out,
                       want_reply.buffer_offset, want_reply.buffer_length,
                       want_reply.status_bits);
              $display("%0t:          exp ovf=%0d drop=%0d data=%h",
                       $time, want_reply.overflow, want_reply.dropped,
                       want_reply.fetch_data);
              $display("%0t:          got ok=%0d ch=%0d off=%h len=%0d st=%b",
                       $time, out_data.ok, out_data.channel_out,
                       out_data.buffer_offset, out_data.buffer_length,
                       out_data.status_bits);
              $display("%0t:          got ovf=%0d drop=%0d data=%h",
                       $time, out_data.overflow, out_data.dropped, out_data.fetch_data);
            end
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // Stimulus, reset and end of run
  initial begin
    mpsb_pkg::in_item_t d;
    int                 kind;
    int                 c;
    int                 sel;

    for (int k = 0; k < NCH; k++) begin
      flag_m[k]    = '0;
      fill_m[k][0] = '0;
      fill_m[k][1] = '0;
    end
    writer_ch_m   = 0;
    writer_half_m = 0;
    writer_open_m = 1'b0;

    // Directed: first-free allocate, fills, overflow diversion, swaps, rejects
    d = rand_req(mpsb_pkg::OP_ALLOC, 9);    d.pick_free = 1'b1;        queue_req(d);
    d = rand_req(mpsb_pkg::OP_ALLOC, 15);   d.pick_free = 1'b0;        queue_req(d);
    d = rand_req(mpsb_pkg::OP_WSTART, 0);   d.write_length = '0;       queue_req(d);
    d = rand_req(mpsb_pkg::OP_WBYTE, 0);    d.data_byte = 8'h00;       queue_req(d);
    d = rand_req(mpsb_pkg::OP_WBYTE, 0);    d.data_byte = 8'hFF;       queue_req(d);
    d = rand_req(mpsb_pkg::OP_WSTART, 0);   d.write_length = 12'd2048; queue_req(d);
    d = rand_req(mpsb_pkg::OP_WBYTE, 0);    d.data_byte = 8'hA5;       queue_req(d);
    queue_req(rand_req(mpsb_pkg::OP_RSWAP, 0));
    queue_req(rand_req(mpsb_pkg::OP_RSWAP, 0));
    d = rand_req(mpsb_pkg::OP_FETCH, 0);    d.byte_address = 16'd0;    queue_req(d);
    d = rand_req(mpsb_pkg::OP_FETCH, 0);    d.byte_address = 16'd1;    queue_req(d);
    d = rand_req(mpsb_pkg::OP_FETCH, 0);
    d.byte_address = ADDR_BITS'(HALF);
    queue_req(d);
    queue_req(rand_req(mpsb_pkg::OP_WSTART, 3));
    queue_req(rand_req(mpsb_pkg::OP_WBYTE, 3));
    queue_req(rand_req(mpsb_pkg::OP_FREE, 15));
    queue_req(rand_req(mpsb_pkg::OP_RSWAP, 7));
    d = rand_req(mpsb_pkg::OP_ALLOC, 0);    d.pick_free = 1'b0;        queue_req(d);
    queue_req(rand_req(OP_SPARE6, 5));
    queue_req(rand_req(OP_SPARE7, 10));
    d = rand_req(mpsb_pkg::OP_WSTART, 0);   d.write_length = 12'hFFF;  queue_req(d);
    queue_req(rand_req(mpsb_pkg::OP_FREE, 0));
    queue_req(rand_req(mpsb_pkg::OP_WBYTE, 0));

    // Fill the top half of the last channel past its end, then read it back
    d = rand_req(mpsb_pkg::OP_ALLOC, NCH - 1);  d.pick_free = 1'b0;    queue_req(d);
    queue_req(rand_req(mpsb_pkg::OP_RSWAP, NCH - 1));
    d = rand_req(mpsb_pkg::OP_WSTART, NCH - 1);
    d.write_length = LEN_BITS'(HALF);
    queue_req(d);
    repeat (HALF + 3) queue_req(rand_req(mpsb_pkg::OP_WBYTE, NCH - 1));
    d = rand_req(mpsb_pkg::OP_FETCH, 0);    d.byte_address = 16'hFFFF; queue_req(d);
    d = rand_req(mpsb_pkg::OP_FETCH, 0);
    d.byte_address = ADDR_BITS'(MEM_SIZE - HALF);
    queue_req(d);
    queue_req(rand_req(mpsb_pkg::OP_RSWAP, NCH - 1));

    // Random: write streams into allocated channels, mixed with swaps, fetches, allocates, frees and noise
    while (request_q.size() < TOTAL_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        c = pick_allocated();
        if (c < 0) begin
          c = $urandom_range(0, NCH - 1);
          d = rand_req(mpsb_pkg::OP_ALLOC, c);
          d.pick_free = 1'b0;
          queue_req(d);
        end
        d   = rand_req(mpsb_pkg::OP_WSTART, c);
        sel = $urandom_range(0, 19);
        if (sel < 1)      d.write_length = LEN_BITS'($urandom_range(HALF + 1, 4095));
        else if (sel < 6) d.write_length = LEN_BITS'($urandom_range(HALF / 2, HALF));
        else              d.write_length = LEN_BITS'($urandom_range(0, 64));
        queue_req(d);
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 15) == 0) queue_req(noise_req());
          queue_req(rand_req(mpsb_pkg::OP_WBYTE, $urandom_range(0, NCH - 1)));
        end
      end else if (kind < 60) begin
        c = pick_allocated();
        if (c < 0 || $urandom_range(0, 3) == 0) c = $urandom_range(0, NCH - 1);
        queue_req(rand_req(mpsb_pkg::OP_RSWAP, c));
        repeat ($urandom_range(0, 3)) queue_req(fetch_req());
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 6)) queue_req(fetch_req());
      end else if (kind < 80) begin
        if ($urandom_range(0, 1))
          queue_req(rand_req(mpsb_pkg::OP_ALLOC, $urandom_range(0, NCH - 1)));
        else
          queue_req(rand_req(mpsb_pkg::OP_FREE, $urandom_range(0, NCH - 1)));
      end else if (kind < 83) begin
        // Exhaust the free channels so the last allocate finds none
        repeat (NCH + 1) begin
          d = rand_req(mpsb_pkg::OP_ALLOC, $urandom_range(0, NCH - 1));
          d.pick_free = 1'b1;
          queue_req(d);
        end
        repeat (4) queue_req(rand_req(mpsb_pkg::OP_FREE, $urandom_range(0, NCH - 1)));
      end else begin
        repeat ($urandom_range(1, 4)) queue_req(noise_req());
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests accepted and all replies in
    @(posedge clk);
    while (request_q.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
